### src/seqr_pkg.sv
package seqr_pkg;

  // Result status codes
  localparam logic STATUS_DELIVERED = 1'b0;
  localparam logic STATUS_OVERFLOW  = 1'b1;

  // One numbered record from a source
  typedef struct packed {
    logic [1:0]  source_id;
    logic [31:0] seq_number;
    logic [31:0] record_handle;
    logic        has_state;
    logic [47:0] stamp_time;
  } in_item_t;

  // One delivered or rejected record
  typedef struct packed {
    logic [1:0]  out_source;
    logic [31:0] out_seq;
    logic [31:0] out_handle;
    logic        out_has_state;
    logic [47:0] out_time;
    logic [47:0] latest_time;
    logic        status;
    logic        last;
  } out_item_t;

endpackage

### src/seqr_stream.sv
interface seqr_stream #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/sequence_resequencer_core.sv
// Per-source in-order resequencer.
// records: numbered records (source, sequence number, handle, has-state flag,
//   timestamp). A transfer takes place when valid and ready are both high.
// results: records delivered in order per source, plus one overflow result for
//   a record numbered WINDOW or more beyond the expected number. Earlier
//   numbers and sources at or above SOURCES are dropped with no result.
// A record ahead of the expected number but inside the window is stored in the
//   slot memory. An expected record is held in a pending register and then
//   loaded into the output register; each stored record that follows it in
//   order is read from the slot memory and gives its own result. The rate is
//   set by the single read port of the slot memory: each drained record needs
//   its own read-modify-write.
// The block works on one record at a time; it takes no new record until all
//   results of the current one have entered the output register. When the
//   receiver stalls the output register holds and the drain waits.
// Reset starts a clearing pass over the SOURCES*2^ceil(log2(WINDOW)) slot
//   entries (64 with the defaults) and the source memory; records are not
//   accepted during that pass.
module sequence_resequencer_core #(
  parameter int SOURCES = 4,
  parameter int WINDOW  = 16
) (
  input  logic        clk,
  input  logic        rst,
  seqr_stream.sink    records,
  seqr_stream.source  results
);

  localparam int SRC_W      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int LW         = $clog2(WINDOW);
  localparam int AW         = SRC_W + LW;
  localparam int SLOT_DEPTH = SOURCES * (2 ** LW);
  localparam int CNT_W      = $clog2(WINDOW + 1);

  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [31:0] handle;
    logic        flag;
    logic [47:0] stamp;
  } slot_t;

  typedef struct packed {
    logic [31:0] next_exp;
    logic [47:0] newest;
  } src_state_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state;

  // Memories
  slot_t      slot_mem [SLOT_DEPTH];
  src_state_t src_mem  [SOURCES];

  logic             slot_we, slot_re;
  logic [AW-1:0]    slot_waddr, slot_raddr;
  slot_t            slot_wdata, slot_rd;
  logic             src_we, src_re;
  logic [SRC_W-1:0] src_waddr, src_raddr;
  src_state_t       src_wdata, src_rd;

  // Working registers
  logic [AW-1:0]           clr_cnt;
  seqr_pkg::in_item_t      item;
  seqr_pkg::out_item_t     pending;
  seqr_pkg::out_item_t     out_reg;
  logic                    out_valid;
  logic [31:0]             cand;
  logic [47:0]             newest;
  logic [CNT_W-1:0]        dcnt;

  logic             accept, out_free, out_load, src_ok, clr_done;
  logic [SRC_W-1:0] in_src, item_src;
  logic [31:0]      diff, next_p1, cand_p1;
  logic             is_less, is_eq, in_win, hit;
  logic [47:0]      look_newest, drain_newest;

  function automatic logic [47:0] raise_time(logic [47:0] cur, logic flag, logic [47:0] t);
    return (flag && t > cur) ? t : cur;
  endfunction

  assign records.ready = (state == S_IDLE);
  assign accept        = records.valid && records.ready;
  assign out_free      = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign results.data  = out_reg;

  assign in_src   = SRC_W'(records.data.source_id);
  assign src_ok   = (32'(records.data.source_id) < SOURCES);
  assign item_src = SRC_W'(item.source_id);
  assign clr_done = (clr_cnt == AW'(SLOT_DEPTH - 1));

  // Classify the record against the expected number
  assign diff        = item.seq_number - src_rd.next_exp;
  assign is_less     = item.seq_number < src_rd.next_exp;
  assign is_eq       = item.seq_number == src_rd.next_exp;
  assign in_win      = diff < 32'(WINDOW);
  assign next_p1     = src_rd.next_exp + 32'd1;
  assign look_newest = raise_time(src_rd.newest, item.has_state, item.stamp_time);

  // Drain: the slot just read holds the next record in order
  assign cand_p1      = cand + 32'd1;
  assign hit          = slot_rd.valid && (slot_rd.seq == cand) && (dcnt < CNT_W'(WINDOW));
  assign drain_newest = raise_time(newest, slot_rd.flag, slot_rd.stamp);

  // Load the output register on a delivery or an overflow reject
  assign out_load = out_free &&
                    ((state == S_DRAIN) || ((state == S_LOOK) && !is_eq && !is_less && !in_win));

  // Memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = {item_src, item.seq_number[LW-1:0]};
    slot_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = {item_src, next_p1[LW-1:0]};
    src_we     = 1'b0;
    src_waddr  = item_src;
    src_wdata  = '{next_exp: cand, newest: newest};
    src_re     = accept && src_ok;
    src_raddr  = in_src;
    unique case (state)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt;
        src_we     = (clr_cnt < AW'(SOURCES));
        src_waddr  = clr_cnt[SRC_W-1:0];
        src_wdata  = '0;
      end
      S_IDLE: begin
      end
      S_LOOK: begin
        if (!is_less && !is_eq && in_win) begin
          slot_we    = 1'b1;
          slot_wdata = '{valid: 1'b1, seq: item.seq_number, handle: item.record_handle,
                         flag: item.has_state, stamp: item.stamp_time};
        end
        slot_re = is_eq;
      end
      S_DRAIN: begin
        if (out_free && hit) begin
          slot_we    = 1'b1;
          slot_waddr = {item_src, cand[LW-1:0]};
          slot_re    = 1'b1;
          slot_raddr = {item_src, cand_p1[LW-1:0]};
        end
        src_we = out_free && !hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_waddr] <= src_wdata;
    if (src_re) src_rd <= src_mem[src_raddr];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            item <= records.data;
            if (src_ok) state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (is_eq) begin
            // Hold the expected record until the next slot is known
            newest  <= look_newest;
            cand    <= next_p1;
            dcnt    <= CNT_W'(1);
            pending <= '{out_source: item.source_id, out_seq: item.seq_number,
                         out_handle: item.record_handle, out_has_state: item.has_state,
                         out_time: item.stamp_time, latest_time: look_newest,
                         status: seqr_pkg::STATUS_DELIVERED, last: 1'b0};
            state   <= S_DRAIN;
          end else if (is_less || in_win) begin
            state <= S_IDLE;
          end else if (out_free) begin
            // Reject: echo the record with the source's latest time
            out_reg   <= '{out_source: item.source_id, out_seq: item.seq_number,
                           out_handle: item.record_handle, out_has_state: item.has_state,
                           out_time: item.stamp_time, latest_time: src_rd.newest,
                           status: seqr_pkg::STATUS_OVERFLOW, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            // Mark the final result when no stored record follows
            out_reg <= {pending[$bits(seqr_pkg::out_item_t)-1:1], !hit};
            if (hit) begin
              // Advance to the drained record
              newest  <= drain_newest;
              cand    <= cand_p1;
              dcnt    <= dcnt + CNT_W'(1);
              pending <= '{out_source: item.source_id, out_seq: cand,
                           out_handle: slot_rd.handle, out_has_state: slot_rd.flag,
                           out_time: slot_rd.stamp, latest_time: drain_newest,
                           status: seqr_pkg::STATUS_DELIVERED, last: 1'b0};
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
